// ===== hw/rtl/bba_pkg.sv =====
// Shared types, constants and helpers for the buddy block allocator.
// Used by bba_ctrl, bba_dpath and buddy_block_allocator; no dependencies.
`default_nettype none
package bba_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int MAX_ORDER  = 10;
  localparam int IDX_W      = 10;
  localparam int LNK_W      = 11;
  localparam int ORD_W      = 4;
  localparam int CNT_W      = 11;
  localparam int SIZE_W     = 31;

  localparam logic [LNK_W-1:0]  NIL_LINK   = LNK_W'(MAX_BLOCKS);
  localparam logic [SIZE_W-1:0] SIZE_LIMIT = 31'h4000_0000;

  localparam logic REG_ATOM_LOG2   = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    RS_OK      = 2'd0,
    RS_NOFIT   = 2'd1,
    RS_BADSIZE = 2'd2,
    RS_BADFREE = 2'd3
  } code_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR_START,
    OP_CLR,
    OP_CARVE,
    OP_CAPTURE,
    OP_A_ORD,
    OP_A_TAKE,
    OP_A_UNL,
    OP_SPLIT1,
    OP_LINK2,
    OP_A_FIN,
    OP_F_MARK,
    OP_F_RDBUD,
    OP_F_RDLNK,
    OP_F_UNL,
    OP_MRG1,
    OP_MRG2,
    OP_LINK1,
    OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    op_t   op;
    code_t code;
  } cmd_t;

  typedef struct packed {
    logic size_bad;
    logic ord_big;
    logic none_fit;
    logic split_more;
    logic free_bad;
    logic merge_try;
    logic bud_match;
    logic clr_last;
    logic carve_last;
  } dp_stat_t;

  // ceil(log2(v)) for v >= 1
  function automatic logic [4:0] ceil_log2(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] w;
    logic [4:0]        r;
    w = v - SIZE_W'(1);
    r = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (w[i]) r = 5'(i + 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bba_ctrl.sv =====
// Sequencing state machine of the buddy block allocator.
// Depends on bba_pkg; drives bba_dpath through cmd_t, reads dp_stat_t.
`default_nettype none
module bba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_req_type,
  input  wire logic              cfg_we,
  input  wire logic              out_stall,
  input  wire bba_pkg::dp_stat_t stat,
  output bba_pkg::cmd_t          cmd,
  output logic                   in_stall,
  output logic                   out_valid
);

  typedef enum logic [4:0] {
    S_INIT, S_CLR, S_CARVE, S_IDLE,
    S_A_ORD, S_A_FIND, S_A_UNL, S_A_SPLIT, S_A_SPLIT2,
    S_F_CHK, S_F_LOOP, S_F_CMPB, S_F_UNL, S_F_MRG1, S_F_MRG2, S_F_LINK2,
    S_RESP
  } state_t;

  state_t             state_r, state_nxt;
  bba_pkg::code_t     code_r, code_nxt;
  logic               out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE) || cfg_we;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = bba_pkg::OP_NONE;
    cmd.code      = code_r;
    case (state_r)
      S_INIT: begin
        cmd.op    = bba_pkg::OP_CLR_START;
        state_nxt = S_CLR;
      end
      S_CLR: begin
        cmd.op = bba_pkg::OP_CLR;
        if (stat.clr_last) state_nxt = S_CARVE;
      end
      S_CARVE: begin
        cmd.op = bba_pkg::OP_CARVE;
        if (stat.carve_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !cfg_we) begin
          cmd.op    = bba_pkg::OP_CAPTURE;
          state_nxt = in_req_type ? S_F_CHK : S_A_ORD;
        end
      end
      S_A_ORD: begin
        if (stat.size_bad) begin
          code_nxt  = bba_pkg::RS_BADSIZE;
          state_nxt = S_RESP;
        end else if (stat.ord_big) begin
          code_nxt  = bba_pkg::RS_NOFIT;
          state_nxt = S_RESP;
        end else begin
          cmd.op    = bba_pkg::OP_A_ORD;
          state_nxt = S_A_FIND;
        end
      end
      S_A_FIND: begin
        if (stat.none_fit) begin
          code_nxt  = bba_pkg::RS_NOFIT;
          state_nxt = S_RESP;
        end else begin
          cmd.op    = bba_pkg::OP_A_TAKE;
          state_nxt = S_A_UNL;
        end
      end
      S_A_UNL: begin
        cmd.op    = bba_pkg::OP_A_UNL;
        state_nxt = S_A_SPLIT;
      end
      S_A_SPLIT: begin
        if (stat.split_more) begin
          cmd.op    = bba_pkg::OP_SPLIT1;
          state_nxt = S_A_SPLIT2;
        end else begin
          cmd.op    = bba_pkg::OP_A_FIN;
          code_nxt  = bba_pkg::RS_OK;
          state_nxt = S_RESP;
        end
      end
      S_A_SPLIT2: begin
        cmd.op    = bba_pkg::OP_LINK2;
        state_nxt = S_A_SPLIT;
      end
      S_F_CHK: begin
        if (stat.free_bad) begin
          code_nxt  = bba_pkg::RS_BADFREE;
          state_nxt = S_RESP;
        end else begin
          cmd.op    = bba_pkg::OP_F_MARK;
          state_nxt = S_F_LOOP;
        end
      end
      S_F_LOOP: begin
        if (stat.merge_try) begin
          cmd.op    = bba_pkg::OP_F_RDBUD;
          state_nxt = S_F_CMPB;
        end else begin
          cmd.op    = bba_pkg::OP_LINK1;
          state_nxt = S_F_LINK2;
        end
      end
      S_F_CMPB: begin
        if (stat.bud_match) begin
          cmd.op    = bba_pkg::OP_F_RDLNK;
          state_nxt = S_F_UNL;
        end else begin
          cmd.op    = bba_pkg::OP_LINK1;
          state_nxt = S_F_LINK2;
        end
      end
      S_F_UNL: begin
        cmd.op    = bba_pkg::OP_F_UNL;
        state_nxt = S_F_MRG1;
      end
      S_F_MRG1: begin
        cmd.op    = bba_pkg::OP_MRG1;
        state_nxt = S_F_MRG2;
      end
      S_F_MRG2: begin
        cmd.op    = bba_pkg::OP_MRG2;
        state_nxt = S_F_LOOP;
      end
      S_F_LINK2: begin
        cmd.op    = bba_pkg::OP_LINK2;
        code_nxt  = bba_pkg::RS_OK;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // wait for the output register to drain
        if (!out_valid_r || !out_stall) begin
          cmd.op        = bba_pkg::OP_OUT_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
    if (cfg_we) state_nxt = S_INIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      code_r      <= bba_pkg::RS_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_cfg_recarve: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (state_r == S_INIT))
    else $error("config write did not restart the carve");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_A_ORD || state_r == S_F_CHK))
    else $error("accepted item not dispatched");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/bba_dpath.sv =====
// Datapath of the buddy block allocator: config registers, list heads,
// link and header memories, output register. Depends on bba_pkg.
`default_nettype none
module bba_dpath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bba_pkg::cmd_t                cmd,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [bba_pkg::CNT_W-1:0]    cfg_wdata,
  input  wire logic [bba_pkg::SIZE_W-1:0]   in_size_bytes,
  input  wire logic [bba_pkg::IDX_W-1:0]    in_block_index,
  output bba_pkg::dp_stat_t                 stat,
  output logic [1:0]                        out_status,
  output logic [bba_pkg::IDX_W-1:0]         out_granted_index,
  output logic [bba_pkg::ORD_W-1:0]         out_granted_order
);

  localparam int IW = bba_pkg::IDX_W;
  localparam int LW = bba_pkg::LNK_W;
  localparam int OW = bba_pkg::ORD_W;
  localparam int CW = bba_pkg::CNT_W;

  logic [3:0]     atom_r;
  logic [CW-1:0]  bcnt_r;
  logic [LW-1:0]  head_r [0:bba_pkg::MAX_ORDER];

  logic [bba_pkg::SIZE_W-1:0] size_r;
  logic [IW-1:0]  blk_r, bud_r, half_r, clr_r;
  logic [OW-1:0]  ord_r, bin_r, kc_r;
  logic [LW-1:0]  hd_r, off_r;
  logic [4:0]     rd_ctrl_r;
  logic [LW-1:0]  rd_next_r, rd_prev_r;
  logic [1:0]     ostat_r;
  logic [IW-1:0]  oidx_r;
  logic [OW-1:0]  oord_r;

  logic [4:0]     ctrl_mem [0:bba_pkg::MAX_BLOCKS-1];
  logic [LW-1:0]  next_mem [0:bba_pkg::MAX_BLOCKS-1];
  logic [LW-1:0]  prev_mem [0:bba_pkg::MAX_BLOCKS-1];

  logic [CW-1:0]  cnt;
  logic [3:0]     sh;
  logic [4:0]     clog, ord5;
  logic [OW-1:0]  fbin, bin_m1, hsel, fo;
  logic           none;
  logic [LW-1:0]  hd;
  logic [IW-1:0]  half, bud, low, high;
  logic [11:0]    fsize, carve_end;
  logic           fits;

  logic           c_we, n_we, p_we, c_re, n_re, p_re, h_we;
  logic [IW-1:0]  c_wa, n_wa, p_wa, c_ra, n_ra;
  logic [4:0]     c_wd;
  logic [LW-1:0]  n_wd, p_wd, h_wd;

  assign cnt = (bcnt_r > CW'(bba_pkg::MAX_BLOCKS)) ? CW'(bba_pkg::MAX_BLOCKS) : bcnt_r;
  assign sh  = (atom_r < 4'd3) ? 4'd3 : ((atom_r > 4'd12) ? 4'd12 : atom_r);

  assign clog = bba_pkg::ceil_log2(size_r);
  assign ord5 = (clog > {1'b0, sh}) ? (clog - {1'b0, sh}) : 5'd0;

  always_comb begin
    none = 1'b1;
    fbin = '0;
    for (int k = bba_pkg::MAX_ORDER; k >= 0; k--) begin
      if (OW'(k) >= ord_r && head_r[k] != bba_pkg::NIL_LINK) begin
        fbin = OW'(k);
        none = 1'b0;
      end
    end
  end

  assign bin_m1 = bin_r - OW'(1);
  assign half   = blk_r + (IW'(1) << bin_m1);
  assign fo     = rd_ctrl_r[3:0];
  assign fsize  = 12'(1) << fo;
  assign bud    = blk_r ^ (IW'(1) << ord_r);
  assign low    = (bud_r < blk_r) ? bud_r : blk_r;
  assign high   = (bud_r < blk_r) ? blk_r : bud_r;
  assign carve_end = {1'b0, off_r} + (12'(1) << kc_r);
  assign fits   = carve_end <= {1'b0, cnt};

  always_comb begin
    case (cmd.op)
      bba_pkg::OP_A_TAKE: hsel = fbin;
      bba_pkg::OP_A_UNL:  hsel = bin_r;
      bba_pkg::OP_SPLIT1: hsel = bin_m1;
      bba_pkg::OP_CARVE:  hsel = kc_r;
      default:            hsel = ord_r;
    endcase
  end
  assign hd = head_r[hsel];

  always_comb begin
    stat.size_bad   = (size_r == '0) || (size_r > bba_pkg::SIZE_LIMIT);
    stat.ord_big    = ord5 > 5'(bba_pkg::MAX_ORDER);
    stat.none_fit   = none;
    stat.split_more = bin_r > ord_r;
    stat.free_bad   = ({1'b0, blk_r} >= cnt) || rd_ctrl_r[4]
                   || (fo > OW'(bba_pkg::MAX_ORDER))
                   || (({2'b0, blk_r} & (fsize - 12'd1)) != 12'd0)
                   || (({2'b0, blk_r} + fsize) > {1'b0, cnt});
    stat.merge_try  = (ord_r < OW'(bba_pkg::MAX_ORDER)) && ({1'b0, bud} < cnt);
    stat.bud_match  = rd_ctrl_r == {1'b1, ord_r};
    stat.clr_last   = &clr_r;
    stat.carve_last = kc_r == '0;
  end

  // memory and head-write port steering
  always_comb begin
    c_we = 1'b0; c_wa = blk_r; c_wd = '0;
    n_we = 1'b0; n_wa = blk_r; n_wd = hd;
    p_we = 1'b0; p_wa = blk_r; p_wd = bba_pkg::NIL_LINK;
    c_re = 1'b0; c_ra = bud;
    n_re = 1'b0; n_ra = bud_r;
    p_re = 1'b0;
    h_we = 1'b0; h_wd = rd_next_r;
    case (cmd.op)
      bba_pkg::OP_CLR: begin
        c_we = 1'b1; c_wa = clr_r;
      end
      bba_pkg::OP_CARVE: begin
        if (fits) begin
          c_we = 1'b1; c_wa = off_r[IW-1:0]; c_wd = {1'b1, kc_r};
          n_we = 1'b1; n_wa = off_r[IW-1:0]; n_wd = bba_pkg::NIL_LINK;
          p_we = 1'b1; p_wa = off_r[IW-1:0];
          h_we = 1'b1; h_wd = off_r;
        end
      end
      bba_pkg::OP_CAPTURE: begin
        c_re = 1'b1; c_ra = in_block_index;
      end
      bba_pkg::OP_A_TAKE: begin
        n_re = 1'b1; n_ra = hd[IW-1:0];
      end
      bba_pkg::OP_A_UNL: begin
        h_we = 1'b1;
        if (!rd_next_r[LW-1]) begin
          p_we = 1'b1; p_wa = rd_next_r[IW-1:0];
        end
      end
      bba_pkg::OP_SPLIT1: begin
        c_we = 1'b1; c_wa = half; c_wd = {1'b1, bin_m1};
        n_we = 1'b1; n_wa = half;
        p_we = 1'b1; p_wa = half;
        h_we = 1'b1; h_wd = {1'b0, half};
      end
      bba_pkg::OP_LINK2: begin
        if (!hd_r[LW-1]) begin
          p_we = 1'b1; p_wa = hd_r[IW-1:0]; p_wd = {1'b0, half_r};
        end
      end
      bba_pkg::OP_A_FIN: begin
        c_we = 1'b1; c_wd = {1'b0, ord_r};
      end
      bba_pkg::OP_F_MARK: begin
        c_we = 1'b1; c_wd = {1'b1, fo};
      end
      bba_pkg::OP_F_RDBUD: begin
        c_re = 1'b1;
      end
      bba_pkg::OP_F_RDLNK: begin
        n_re = 1'b1; p_re = 1'b1;
      end
      bba_pkg::OP_F_UNL: begin
        if (rd_prev_r[LW-1]) h_we = 1'b1;
        else begin
          n_we = 1'b1; n_wa = rd_prev_r[IW-1:0]; n_wd = rd_next_r;
        end
        if (!rd_next_r[LW-1]) begin
          p_we = 1'b1; p_wa = rd_next_r[IW-1:0]; p_wd = rd_prev_r;
        end
      end
      bba_pkg::OP_MRG1: begin
        c_we = 1'b1; c_wa = low; c_wd = {1'b1, ord_r + OW'(1)};
      end
      bba_pkg::OP_MRG2: begin
        c_we = 1'b1; c_wa = high;
      end
      bba_pkg::OP_LINK1: begin
        n_we = 1'b1;
        p_we = 1'b1;
        h_we = 1'b1; h_wd = {1'b0, blk_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (c_we) ctrl_mem[c_wa] <= c_wd;
    if (c_re) rd_ctrl_r <= ctrl_mem[c_ra];
  end

  always_ff @(posedge clk) begin
    if (n_we) next_mem[n_wa] <= n_wd;
    if (n_re) rd_next_r <= next_mem[n_ra];
  end

  always_ff @(posedge clk) begin
    if (p_we) prev_mem[p_wa] <= p_wd;
    if (p_re) rd_prev_r <= prev_mem[n_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atom_r <= 4'd4;
      bcnt_r <= CW'(bba_pkg::MAX_BLOCKS);
    end else if (cfg_we) begin
      case (cfg_index)
        bba_pkg::REG_ATOM_LOG2:   atom_r <= cfg_wdata[3:0];
        bba_pkg::REG_BLOCK_COUNT: bcnt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == bba_pkg::OP_CLR_START) begin
      for (int k = 0; k <= bba_pkg::MAX_ORDER; k++) head_r[k] <= bba_pkg::NIL_LINK;
    end else if (h_we) begin
      head_r[hsel] <= h_wd;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      bba_pkg::OP_CLR_START: begin
        clr_r <= '0;
        off_r <= '0;
        kc_r  <= OW'(bba_pkg::MAX_ORDER);
      end
      bba_pkg::OP_CLR: clr_r <= clr_r + IW'(1);
      bba_pkg::OP_CARVE: begin
        if (fits) off_r <= carve_end[LW-1:0];
        kc_r <= kc_r - OW'(1);
      end
      bba_pkg::OP_CAPTURE: begin
        size_r <= in_size_bytes;
        blk_r  <= in_block_index;
      end
      bba_pkg::OP_A_ORD:  ord_r <= ord5[OW-1:0];
      bba_pkg::OP_A_TAKE: begin
        bin_r <= fbin;
        blk_r <= hd[IW-1:0];
      end
      bba_pkg::OP_SPLIT1: begin
        bin_r  <= bin_m1;
        hd_r   <= hd;
        half_r <= half;
      end
      bba_pkg::OP_F_MARK:  ord_r <= fo;
      bba_pkg::OP_F_RDBUD: bud_r <= bud;
      bba_pkg::OP_MRG2: begin
        ord_r <= ord_r + OW'(1);
        blk_r <= low;
      end
      bba_pkg::OP_LINK1: begin
        hd_r   <= hd;
        half_r <= blk_r;
      end
      bba_pkg::OP_OUT_LOAD: begin
        ostat_r <= cmd.code;
        if (cmd.code == bba_pkg::RS_OK) begin
          oidx_r <= blk_r;
          oord_r <= ord_r;
        end else begin
          oidx_r <= '0;
          oord_r <= '0;
        end
      end
      default: ;
    endcase
  end

  assign out_status        = ostat_r;
  assign out_granted_index = oidx_r;
  assign out_granted_order = oord_r;

`ifndef SYNTH
  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == bba_pkg::OP_A_TAKE) |-> (hd != bba_pkg::NIL_LINK))
    else $error("allocation took an empty free list");

  a_merge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == bba_pkg::OP_MRG2) |-> (ord_r < OW'(bba_pkg::MAX_ORDER)))
    else $error("merge beyond the top order");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: bba_ctrl sequencer plus bba_dpath.
// Depends on bba_pkg, bba_ctrl and bba_dpath.
//
// Usage: an item on the in_ channel is an allocate (in_req_type 0, size in
// in_size_bytes) or a free (in_req_type 1, in_block_index). Each item gives
// one result on the out_ channel: status, block index and order.
// One item is worked on at a time; each list or header update is a memory
// read or write through link and header RAMs with one write and one read
// port each, which sets rate. An allocate takes and unlinks a free block,
// then splits it down to the order; a free checks, then per buddy merge
// reads the buddy and its links, unlinks and merges, then links the block.
// The next item is taken in the cycle after the result is loaded. The
// output register holds a result while out_stall is high; the next item
// is accepted meanwhile and its result waits until the register drains.
// After reset and after every cfg write the header RAM is cleared and the
// pool carved; in_stall stays high then. cfg writes go through cfg_we/
// cfg_index/cfg_wdata; the user must write only while idle (not enforced).
`default_nettype none
module buddy_block_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_req_type,
  input  wire logic [bba_pkg::SIZE_W-1:0]  in_size_bytes,
  input  wire logic [bba_pkg::IDX_W-1:0]   in_block_index,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic [bba_pkg::IDX_W-1:0]        out_granted_index,
  output logic [bba_pkg::ORD_W-1:0]        out_granted_order,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [bba_pkg::CNT_W-1:0]   cfg_wdata
);

  bba_pkg::cmd_t     cmd;
  bba_pkg::dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .cfg_we      (cfg_we),
    .out_stall   (out_stall),
    .stat        (stat),
    .cmd         (cmd),
    .in_stall    (in_stall),
    .out_valid   (out_valid)
  );

  bba_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_size_bytes     (in_size_bytes),
    .in_block_index    (in_block_index),
    .stat              (stat),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_granted_order (out_granted_order)
  );

endmodule
`default_nettype wire

// ===== verif/buddy_block_allocator_tb.sv =====
// Self-checking testbench for the buddy block allocator: allocate and free items
// are checked against an in-bench model of the free lists and block headers.
// Depends on bba_pkg and the buddy_block_allocator RTL.
`default_nettype none
module buddy_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;
  localparam int WDOG_LIMIT  = 20000;
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;
  localparam logic [7:0] FREE_BIT = 8'h20;

  typedef struct {
    bba_pkg::code_t                status;
    logic [bba_pkg::IDX_W-1:0]     index;
    logic [bba_pkg::ORD_W-1:0]     order;
  } grant_t;

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_valid = 1'b0, in_req_type = 1'b0;
  logic [bba_pkg::SIZE_W-1:0] in_size_bytes = '0;
  logic [bba_pkg::IDX_W-1:0] in_block_index = '0;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0, cfg_index = 1'b0;
  logic [bba_pkg::CNT_W-1:0] cfg_wdata = '0;
  logic in_stall, out_valid;
  logic [1:0] out_status;
  logic [bba_pkg::IDX_W-1:0] out_granted_index;
  logic [bba_pkg::ORD_W-1:0] out_granted_order;

  buddy_block_allocator u_dut (.*);

  initial forever #6 clk = ~clk;

  // model of the pool
  logic [3:0]  atom_reg;
  logic [10:0] count_reg;
  logic [10:0] heads[0:bba_pkg::MAX_ORDER];
  logic [10:0] next_blk[0:bba_pkg::MAX_BLOCKS-1];
  logic [10:0] prev_blk[0:bba_pkg::MAX_BLOCKS-1];
  logic [7:0]  hdr[0:bba_pkg::MAX_BLOCKS-1];

  grant_t grant_q[$];
  int unsigned live_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_req = 0;
  bit no_gaps = 0;
  int burst_left = 0;

  function automatic int unsigned pool_size();
    return (count_reg > bba_pkg::MAX_BLOCKS) ? bba_pkg::MAX_BLOCKS : int'(count_reg);
  endfunction

  function automatic int unsigned atom_sh();
    if (atom_reg < 3) return 3;
    if (atom_reg > 12) return 12;
    return int'(atom_reg);
  endfunction

  function automatic void list_remove(int unsigned b, int unsigned o);
    logic [10:0] nx, pv;
    if (b >= bba_pkg::MAX_BLOCKS || o > bba_pkg::MAX_ORDER) return;
    nx = next_blk[b];
    pv = prev_blk[b];
    if (pv >= bba_pkg::MAX_BLOCKS) heads[o] = nx;
    else next_blk[pv] = nx;
    if (nx < bba_pkg::MAX_BLOCKS) prev_blk[nx] = pv;
  endfunction

  function automatic void list_push(int unsigned b, int unsigned o);
    logic [10:0] hd;
    if (b >= bba_pkg::MAX_BLOCKS || o > bba_pkg::MAX_ORDER) return;
    hd = heads[o];
    next_blk[b] = hd;
    prev_blk[b] = bba_pkg::NIL_LINK;
    if (hd < bba_pkg::MAX_BLOCKS) prev_blk[hd] = 11'(b);
    heads[o] = 11'(b);
  endfunction

  function automatic void carve_pool();
    int unsigned off;
    off = 0;
    for (int i = 0; i < bba_pkg::MAX_BLOCKS; i++) begin
      hdr[i] = '0; next_blk[i] = '0; prev_blk[i] = '0;
    end
    for (int k = 0; k <= bba_pkg::MAX_ORDER; k++) heads[k] = bba_pkg::NIL_LINK;
    for (int k = bba_pkg::MAX_ORDER; k >= 0; k--) begin
      if (off + (1 << k) <= pool_size()) begin
        hdr[off] = FREE_BIT | 8'(k);
        list_push(off, k);
        off += 1 << k;
      end
    end
  endfunction

  function automatic grant_t predict_grant(logic rt, logic [bba_pkg::SIZE_W-1:0] sz,
                                           logic [bba_pkg::IDX_W-1:0] bi);
    grant_t g;
    int unsigned sh, ord, bin, blk, bud, cnt, bsz;
    g = '{bba_pkg::RS_OK, '0, '0};
    if (rt == REQ_ALLOC) begin
      sh = atom_sh();
      if (sz == 0 || sz > bba_pkg::SIZE_LIMIT) begin
        g.status = bba_pkg::RS_BADSIZE; return g;
      end
      ord = 0;
      while (ord < 30 && (64'd1 << (sh + ord)) < 64'(sz)) ord++;
      if (ord > bba_pkg::MAX_ORDER) begin g.status = bba_pkg::RS_NOFIT; return g; end
      bin = ord;
      while (bin <= bba_pkg::MAX_ORDER && heads[bin] >= bba_pkg::MAX_BLOCKS) bin++;
      if (bin > bba_pkg::MAX_ORDER) begin g.status = bba_pkg::RS_NOFIT; return g; end
      blk = heads[bin];
      list_remove(blk, bin);
      while (bin > ord) begin
        bin--;
        if (blk + (1 << bin) < bba_pkg::MAX_BLOCKS) begin
          hdr[blk + (1 << bin)] = FREE_BIT | 8'(bin);
          list_push(blk + (1 << bin), bin);
        end
      end
      hdr[blk] = 8'(ord);
      g.index = bba_pkg::IDX_W'(blk);
      g.order = bba_pkg::ORD_W'(ord);
      return g;
    end
    cnt = pool_size();
    blk = bi;
    if (blk >= cnt || (hdr[blk] & FREE_BIT) != 0) begin
      g.status = bba_pkg::RS_BADFREE; return g;
    end
    ord = hdr[blk] & 8'h1f;
    if (ord > bba_pkg::MAX_ORDER) begin g.status = bba_pkg::RS_BADFREE; return g; end
    bsz = 1 << ord;
    if ((blk & (bsz - 1)) != 0 || blk + bsz > cnt) begin
      g.status = bba_pkg::RS_BADFREE; return g;
    end
    hdr[blk] = FREE_BIT | 8'(ord);
    while (ord < bba_pkg::MAX_ORDER) begin
      bud = blk ^ bsz;
      if (bud >= cnt || hdr[bud] != (FREE_BIT | 8'(ord))) break;
      list_remove(bud, ord);
      ord++;
      if (bud < blk) begin
        hdr[bud] = FREE_BIT | 8'(ord);
        hdr[blk] = '0;
        blk = bud;
      end else begin
        hdr[blk] = FREE_BIT | 8'(ord);
        hdr[bud] = '0;
      end
      bsz <<= 1;
    end
    list_push(blk, ord);
    g.index = bba_pkg::IDX_W'(blk);
    g.order = bba_pkg::ORD_W'(ord);
    return g;
  endfunction

  // sender: bursts of random length separated by random gaps, unless no_gaps is set
  task automatic send_req(logic rt, logic [bba_pkg::SIZE_W-1:0] sz,
                          logic [bba_pkg::IDX_W-1:0] bi);
    grant_t g;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_size_bytes <= sz;
    in_block_index <= bi;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    g = predict_grant(rt, sz, bi);
    grant_q.push_back(g);
    if (rt == REQ_ALLOC && g.status == bba_pkg::RS_OK) live_q.push_back(g.index);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (grant_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic ri, logic [bba_pkg::CNT_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= ri;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (ri == bba_pkg::REG_ATOM_LOG2) atom_reg = val[3:0];
    else count_reg = val;
    carve_pool();
    live_q.delete();
  endtask

  function automatic logic [bba_pkg::SIZE_W-1:0] rand_size();
    int unsigned o, top;
    if ($urandom_range(0, 9) == 0) return bba_pkg::SIZE_W'($urandom);
    o = ($urandom_range(0, 3) == 0) ? $urandom_range(0, bba_pkg::MAX_ORDER)
                                    : $urandom_range(0, 3);
    top = 1 << (atom_sh() + o);
    return bba_pkg::SIZE_W'(top - $urandom_range(0, top / 2 - 1));
  endfunction

  task automatic random_mix(int n);
    int unsigned k, pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 && live_q.size() > 0) begin
        k = $urandom_range(0, live_q.size() - 1);
        send_req(REQ_FREE, bba_pkg::SIZE_W'($urandom), bba_pkg::IDX_W'(live_q[k]));
        live_q.delete(k);
      end else if (pick < 55) begin
        send_req(REQ_FREE, bba_pkg::SIZE_W'($urandom), bba_pkg::IDX_W'($urandom));
      end else begin
        send_req(REQ_ALLOC, rand_size(), bba_pkg::IDX_W'($urandom));
      end
    end
  endtask

  task automatic test_alloc_limits();
    send_req(REQ_ALLOC, '0, '0);
    send_req(REQ_ALLOC, bba_pkg::SIZE_LIMIT, '0);
    send_req(REQ_ALLOC, bba_pkg::SIZE_W'(bba_pkg::SIZE_LIMIT + 1), '0);
    send_req(REQ_ALLOC, '1, '1);
    send_req(REQ_ALLOC, 31'd1, '0);
    send_req(REQ_ALLOC, 31'd17, '0);
    send_req(REQ_ALLOC, 31'd16384, '0);
    send_req(REQ_ALLOC, 31'd1, '0);
  endtask

  task automatic test_free_cases();
    send_req(REQ_FREE, '0, 10'd0);
    send_req(REQ_FREE, '0, 10'd0);     // double free
    send_req(REQ_FREE, '0, 10'd1);     // freshly freed order-0 buddy merge path
    send_req(REQ_ALLOC, 31'd16, '0);
    send_req(REQ_ALLOC, 31'd32, '0);
    send_req(REQ_FREE, '0, 10'd3);     // interior of an order-1 block
    send_req(REQ_FREE, '0, 10'd1023);  // interior, never allocated
    write_reg(bba_pkg::REG_BLOCK_COUNT, 11'd37);
    send_req(REQ_FREE, '0, 10'd40);    // beyond the pool
    send_req(REQ_ALLOC, 31'd600, '0);  // larger than any carved block
    send_req(REQ_ALLOC, 31'd512, '0);
  endtask

  task automatic test_long_hold();
    no_gaps = 1;
    hold_req = 1;
    random_mix(30);
    no_gaps = 0;
  endtask

  task automatic test_config_sweep();
    write_reg(bba_pkg::REG_ATOM_LOG2, 11'd3);
    write_reg(bba_pkg::REG_BLOCK_COUNT, 11'd1);
    random_mix(40);
    write_reg(bba_pkg::REG_ATOM_LOG2, 11'd12);
    write_reg(bba_pkg::REG_BLOCK_COUNT, 11'd1024);
    random_mix(150);
    write_reg(bba_pkg::REG_ATOM_LOG2, 11'd0);
    write_reg(bba_pkg::REG_BLOCK_COUNT, 11'd0);
    random_mix(30);
    write_reg(bba_pkg::REG_ATOM_LOG2, 11'h7ff);
    write_reg(bba_pkg::REG_BLOCK_COUNT, 11'h7ff);
    random_mix(150);
    write_reg(bba_pkg::REG_ATOM_LOG2, 11'd5);
    write_reg(bba_pkg::REG_BLOCK_COUNT, 11'd1000);
    random_mix(150);
    write_reg(bba_pkg::REG_BLOCK_COUNT, 11'd37);
    random_mix(120);
  endtask

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        $error("unexpected result: status %0d index %0d", out_status, out_granted_index);
        errors++;
      end else begin
        g = grant_q.pop_front();
        if (out_status !== g.status) begin
          $error("status exp %0d got %0d", g.status, out_status); errors++;
        end
        if (out_granted_index !== g.index) begin
          $error("granted_index exp %0d got %0d", g.index, out_granted_index); errors++;
        end
        if (out_granted_order !== g.order) begin
          $error("granted_order exp %0d got %0d", g.order, out_granted_order); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("buddy_block_allocator: mismatch");
      $finish;
    end
  end

  initial begin
    atom_reg = 4'd4;
    count_reg = 11'd1024;
    carve_pool();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_alloc_limits();
    test_free_cases();
    write_reg(bba_pkg::REG_BLOCK_COUNT, 11'd1024);
    test_long_hold();
    drain();   // sender waits for every result here
    test_config_sweep();
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("buddy_block_allocator: match");
    end else begin
      $display("buddy_block_allocator: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
